// ----- sv/sdinit_pkg.sv -----
// sdinit_pkg: types, register codes and command words of the SD card bring-up sequencer.
// Used by sd_card_init_sequencer and its testbench; depends on nothing else.
`default_nettype none

package sdinit_pkg;

   localparam int CountWidth = 24;
   typedef logic [CountWidth-1:0] count_type;

   // phase codes
   localparam logic [3:0] PhIdle     = 4'd0;
   localparam logic [3:0] PhPresent  = 4'd1;
   localparam logic [3:0] PhDlySetup = 4'd2;
   localparam logic [3:0] PhCmd0     = 4'd3;
   localparam logic [3:0] PhCmd8     = 4'd4;
   localparam logic [3:0] PhDlyLoop  = 4'd5;
   localparam logic [3:0] PhCmd55    = 4'd6;
   localparam logic [3:0] PhAcmd41   = 4'd7;

   // input opcodes
   localparam logic [1:0] OpTick  = 2'd0;
   localparam logic [1:0] OpPoll  = 2'd1;
   localparam logic [1:0] OpStart = 2'd2;

   // result kinds
   localparam logic KindWrite  = 1'b0;
   localparam logic KindFinish = 1'b1;

   // controller register word indexes
   localparam logic [2:0] RegCmd  = 3'd0;
   localparam logic [2:0] RegData = 3'd1;
   localparam logic [2:0] RegPhy  = 3'd4;

   // finish status codes
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StNoCard    = 3'd1;
   localparam logic [2:0] StCmd0Tmo   = 3'd2;
   localparam logic [2:0] StCmd8Tmo   = 3'd3;
   localparam logic [2:0] StCmd8Err   = 3'd4;
   localparam logic [2:0] StMismatch  = 3'd5;
   localparam logic [2:0] StNotReady  = 3'd6;

   // configuration register indexes
   localparam logic [2:0] CsrPresentTimeout = 3'd0;
   localparam logic [2:0] CsrBusyTimeout    = 3'd1;
   localparam logic [2:0] CsrInitRetries    = 3'd2;
   localparam logic [2:0] CsrSetupDelay     = 3'd3;
   localparam logic [2:0] CsrCmd8Delay      = 3'd4;
   localparam logic [2:0] CsrErrRetryDelay  = 3'd5;
   localparam logic [2:0] CsrBusyRetryDelay = 3'd6;
   localparam logic [2:0] CsrPhyWord        = 3'd7;

   // status word bits and command words
   localparam logic [31:0] BitPresentN = 32'h0008_0000;
   localparam logic [31:0] BitRemoved  = 32'h0004_0000;
   localparam logic [31:0] BitNullCmd  = 32'h0000_0080;
   localparam logic [31:0] BitCmdFlag  = 32'h0000_0040;
   localparam logic [31:0] BitR1       = 32'h0000_0100;
   localparam logic [31:0] BitErrClr   = 32'h0000_8000;
   localparam logic [31:0] MaskBusy    = 32'h0010_6800;
   localparam logic [31:0] BitErr      = 32'h0000_8000;
   localparam logic [31:0] ArgCmd8     = 32'h0000_01AA;
   localparam logic [31:0] ArgAcmd41   = 32'h40FF_8000;
   localparam logic [7:0]  EchoPattern = 8'hAA;

   localparam logic [31:0] CmdWord0  = BitCmdFlag | BitErrClr;
   localparam logic [31:0] CmdWord8  = BitCmdFlag | BitR1 | BitErrClr | 32'd8;
   localparam logic [31:0] CmdWord55 = BitCmdFlag | BitR1 | BitErrClr | 32'd55;
   localparam logic [31:0] CmdWord41 = BitCmdFlag | BitR1 | BitErrClr | 32'd41;
   localparam logic [31:0] ClearWord = BitRemoved | BitNullCmd;

   // result queue
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] cmd_status;
      logic [31:0] data_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  reg_index;
      logic [31:0] reg_value;
      logic [2:0]  status;
      logic [31:0] ocr;
      logic        high_capacity;
      logic        last;
   } rsp_type;

   function automatic rsp_type make_write(input logic [2:0] idx, input logic [31:0] val);
      rsp_type r;
      r = '0;
      r.kind      = KindWrite;
      r.reg_index = idx;
      r.reg_value = val;
      return r;
   endfunction

   function automatic rsp_type make_finish(input logic [2:0] st, input logic [31:0] ocr,
                                           input logic hc);
      rsp_type r;
      r = '0;
      r.kind          = KindFinish;
      r.status        = st;
      r.ocr           = ocr;
      r.high_capacity = hc;
      r.last          = 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/sd_card_init_sequencer.sv -----
// sd_card_init_sequencer: SD card bring-up sequencer that emits controller register writes.
// Depends on sdinit_pkg (types, phase codes, command words).
// An accepted transaction's results enter the registered result queue and go out on rsp
// after the results ahead of them. One transaction per cycle is accepted while two queue
// slots are free; the single result port drains the 4-entry queue.
// Reset (synchronous): phase idle, counters zero, configuration to defaults, queue empty.
`default_nettype none

module sd_card_init_sequencer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  sdinit_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output sdinit_pkg::rsp_type rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [2:0]          csr_index,
   input  wire  [31:0]         csr_data
);

   // ---------------------------------------------------------------- configuration
   logic [23:0] present_timeout_ff;
   logic [23:0] busy_timeout_ff;
   logic [7:0]  init_retries_ff;
   logic [15:0] setup_delay_ff;
   logic [15:0] cmd8_delay_ff;
   logic [15:0] err_retry_delay_ff;
   logic [15:0] busy_retry_delay_ff;
   logic [31:0] phy_word_ff;

   // Always ready; software must write only while the block is idle; not enforced here.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_timeout_ff  <= 24'd10000000;
         busy_timeout_ff     <= 24'd100000;
         init_retries_ff     <= 8'd200;
         setup_delay_ff      <= 16'd10000;
         cmd8_delay_ff       <= 16'd50000;
         err_retry_delay_ff  <= 16'd10000;
         busy_retry_delay_ff <= 16'd5000;
         phy_word_ff         <= 32'h0900_00FC;
      end else if (csr_valid) begin
         case (csr_index)
            sdinit_pkg::CsrPresentTimeout: present_timeout_ff  <= csr_data[23:0];
            sdinit_pkg::CsrBusyTimeout:    busy_timeout_ff     <= csr_data[23:0];
            sdinit_pkg::CsrInitRetries:    init_retries_ff     <= csr_data[7:0];
            sdinit_pkg::CsrSetupDelay:     setup_delay_ff      <= csr_data[15:0];
            sdinit_pkg::CsrCmd8Delay:      cmd8_delay_ff       <= csr_data[15:0];
            sdinit_pkg::CsrErrRetryDelay:  err_retry_delay_ff  <= csr_data[15:0];
            sdinit_pkg::CsrBusyRetryDelay: busy_retry_delay_ff <= csr_data[15:0];
            sdinit_pkg::CsrPhyWord:        phy_word_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer state
   logic [3:0]            phase_ff, phase_in;
   sdinit_pkg::count_type countdown_ff, countdown_in;
   logic [7:0]            retries_ff, retries_in;

   // ---------------------------------------------------------------- result queue
   sdinit_pkg::rsp_type                  queue_ff [sdinit_pkg::QueueDepth];
   logic [sdinit_pkg::QueuePtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [sdinit_pkg::QueueCntW-1:0]     count_ff, count_in;

   logic                req_fire;
   logic                rsp_fire;
   logic [1:0]          push_num;
   sdinit_pkg::rsp_type res0, res1;

   // Accept only while two slots are free, so one transaction's writes always fit.
   assign req_ready = (count_ff <= sdinit_pkg::QueueCntW'(sdinit_pkg::QueueDepth - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign rsp_fire  = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------- next-state logic
   sdinit_pkg::count_type cd_dec;   // decrement, saturating at zero (delays)
   sdinit_pkg::count_type cd_wrap;  // decrement modulo 2^CountWidth (timeouts)
   logic                  not_busy;
   logic [7:0]            retries_dec;

   assign cd_wrap     = countdown_ff - sdinit_pkg::count_type'(1);
   assign cd_dec      = (countdown_ff != '0) ? cd_wrap : countdown_ff;
   assign not_busy    = ((req_data.cmd_status & sdinit_pkg::MaskBusy) == '0);
   assign retries_dec = (retries_ff != '0) ? retries_ff - 8'd1 : retries_ff;

   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      retries_in   = retries_ff;
      push_num     = 2'd0;
      res0         = '0;
      res1         = '0;

      case (req_data.opcode)
         sdinit_pkg::OpStart: begin
            // restart from the presence wait; emits nothing
            phase_in     = sdinit_pkg::PhPresent;
            countdown_in = sdinit_pkg::count_type'(present_timeout_ff);
            retries_in   = 8'd0;
         end

         sdinit_pkg::OpTick: begin
            if (phase_ff == sdinit_pkg::PhDlySetup || phase_ff == sdinit_pkg::PhDlyLoop) begin
               countdown_in = cd_dec;
               if (cd_dec == '0) begin
                  if (phase_ff == sdinit_pkg::PhDlySetup) begin
                     // issue CMD0
                     res0         = sdinit_pkg::make_write(sdinit_pkg::RegData, 32'd0);
                     res1         = sdinit_pkg::make_write(sdinit_pkg::RegCmd,
                                                           sdinit_pkg::CmdWord0);
                     push_num     = 2'd2;
                     phase_in     = sdinit_pkg::PhCmd0;
                     countdown_in = sdinit_pkg::count_type'(busy_timeout_ff);
                  end else if (retries_ff == '0) begin
                     res0         = sdinit_pkg::make_finish(sdinit_pkg::StNotReady, '0, 1'b0);
                     push_num     = 2'd1;
                     phase_in     = sdinit_pkg::PhIdle;
                     countdown_in = '0;
                  end else begin
                     res0     = sdinit_pkg::make_write(sdinit_pkg::RegData, 32'd0);
                     res1     = sdinit_pkg::make_write(sdinit_pkg::RegCmd,
                                                       sdinit_pkg::CmdWord55);
                     push_num = 2'd2;
                     phase_in = sdinit_pkg::PhCmd55;
                  end
               end
            end
         end

         sdinit_pkg::OpPoll: begin
            case (phase_ff)
               sdinit_pkg::PhPresent: begin
                  countdown_in = cd_wrap;
                  if (cd_wrap == '0) begin
                     res0         = sdinit_pkg::make_finish(sdinit_pkg::StNoCard, '0, 1'b0);
                     push_num     = 2'd1;
                     phase_in     = sdinit_pkg::PhIdle;
                     countdown_in = '0;
                  end else if ((req_data.cmd_status & sdinit_pkg::BitPresentN) == '0) begin
                     // clear flags, program the PHY
                     res0         = sdinit_pkg::make_write(sdinit_pkg::RegCmd,
                                                           sdinit_pkg::ClearWord);
                     res1         = sdinit_pkg::make_write(sdinit_pkg::RegPhy, phy_word_ff);
                     push_num     = 2'd2;
                     phase_in     = sdinit_pkg::PhDlySetup;
                     countdown_in = sdinit_pkg::count_type'(setup_delay_ff);
                  end
               end

               sdinit_pkg::PhCmd0: begin
                  countdown_in = cd_wrap;
                  if (cd_wrap == '0) begin
                     res0         = sdinit_pkg::make_finish(sdinit_pkg::StCmd0Tmo, '0, 1'b0);
                     push_num     = 2'd1;
                     phase_in     = sdinit_pkg::PhIdle;
                     countdown_in = '0;
                  end else if (not_busy) begin
                     res0         = sdinit_pkg::make_write(sdinit_pkg::RegData,
                                                           sdinit_pkg::ArgCmd8);
                     res1         = sdinit_pkg::make_write(sdinit_pkg::RegCmd,
                                                           sdinit_pkg::CmdWord8);
                     push_num     = 2'd2;
                     phase_in     = sdinit_pkg::PhCmd8;
                     countdown_in = sdinit_pkg::count_type'(busy_timeout_ff);
                  end
               end

               sdinit_pkg::PhCmd8: begin
                  countdown_in = cd_wrap;
                  if (cd_wrap == '0) begin
                     res0         = sdinit_pkg::make_finish(sdinit_pkg::StCmd8Tmo, '0, 1'b0);
                     push_num     = 2'd1;
                     phase_in     = sdinit_pkg::PhIdle;
                     countdown_in = '0;
                  end else if (not_busy) begin
                     if ((req_data.cmd_status & sdinit_pkg::BitErr) != '0) begin
                        res0         = sdinit_pkg::make_finish(sdinit_pkg::StCmd8Err, '0, 1'b0);
                        push_num     = 2'd1;
                        phase_in     = sdinit_pkg::PhIdle;
                        countdown_in = '0;
                     end else if (req_data.data_word[7:0] != sdinit_pkg::EchoPattern) begin
                        res0         = sdinit_pkg::make_finish(sdinit_pkg::StMismatch, '0, 1'b0);
                        push_num     = 2'd1;
                        phase_in     = sdinit_pkg::PhIdle;
                        countdown_in = '0;
                     end else begin
                        retries_in   = init_retries_ff;
                        phase_in     = sdinit_pkg::PhDlyLoop;
                        countdown_in = sdinit_pkg::count_type'(cmd8_delay_ff);
                     end
                  end
               end

               sdinit_pkg::PhCmd55: begin
                  if (not_busy) begin
                     if ((req_data.cmd_status & sdinit_pkg::BitErr) != '0) begin
                        retries_in   = retries_dec;
                        phase_in     = sdinit_pkg::PhDlyLoop;
                        countdown_in = sdinit_pkg::count_type'(err_retry_delay_ff);
                     end else begin
                        res0     = sdinit_pkg::make_write(sdinit_pkg::RegData,
                                                          sdinit_pkg::ArgAcmd41);
                        res1     = sdinit_pkg::make_write(sdinit_pkg::RegCmd,
                                                          sdinit_pkg::CmdWord41);
                        push_num = 2'd2;
                        phase_in = sdinit_pkg::PhAcmd41;
                     end
                  end
               end

               sdinit_pkg::PhAcmd41: begin
                  if (not_busy) begin
                     if (req_data.data_word[31]) begin
                        res0         = sdinit_pkg::make_finish(sdinit_pkg::StOk,
                                                               req_data.data_word,
                                                               req_data.data_word[30]);
                        push_num     = 2'd1;
                        phase_in     = sdinit_pkg::PhIdle;
                        countdown_in = '0;
                     end else begin
                        retries_in   = retries_dec;
                        phase_in     = sdinit_pkg::PhDlyLoop;
                        countdown_in = sdinit_pkg::count_type'(busy_retry_delay_ff);
                     end
                  end
               end

               default: ;
            endcase
         end

         default: ;
      endcase

      // mark the final result of this transaction
      if (push_num == 2'd1) begin
         res0.last = 1'b1;
      end else if (push_num == 2'd2) begin
         res0.last = 1'b0;
         res1.last = 1'b1;
      end
   end

   // ---------------------------------------------------------------- state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdinit_pkg::PhIdle;
         countdown_ff <= '0;
         retries_ff   <= '0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         retries_ff   <= retries_in;
      end
   end

   // ---------------------------------------------------------------- queue control
   logic [1:0] push_eff;

   assign push_eff = req_fire ? push_num : 2'd0;
   assign count_in = count_ff + sdinit_pkg::QueueCntW'(push_eff)
                   - sdinit_pkg::QueueCntW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + sdinit_pkg::QueuePtrW'(push_eff);
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + sdinit_pkg::QueuePtrW'(1);
         end
         count_ff <= count_in;
      end
   end

   // queue payload: hold until overwritten, no reset
   always_ff @(posedge clock) begin
      if (push_eff != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_eff == 2'd2) begin
         queue_ff[wr_ptr_ff + sdinit_pkg::QueuePtrW'(1)] <= res1;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdinit_pkg::QueueCntW'(sdinit_pkg::QueueDepth))
      else $error("result queue overflow");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sdinit_pkg::PhIdle |-> countdown_ff == '0)
      else $error("countdown left nonzero in idle");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_num != 2'd0) |=> rsp_valid)
      else $error("pushed result not presented");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == sdinit_pkg::KindFinish) |-> rsp_data.last)
      else $error("finish result not marked last");

endmodule

`default_nettype wire

// ----- tb/sd_card_init_sequencer_test.sv -----
// Self-checking testbench for sd_card_init_sequencer: directed bring-up sequences,
// long delay walks and phase-aware random card traffic, scored against an in-bench predictor.
// Depends on sdinit_pkg and sd_card_init_sequencer; needs no files or arguments.

module sd_card_init_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sdinit_pkg::*;

   // Opcode that the sequencer must ignore.
   localparam logic [1:0] OpUnused = 2'd3;

   // Hard stop for a hung run; the slowest legal run stays far below this.
   localparam int unsigned CycleLimit  = 3_000_000;

   // ---------------------------------------------------------------------------------------
   // Clock, reset and block inputs; every input is known from time zero.
   // ---------------------------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data  = '0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_ready;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sd_card_init_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Sequencer predictor: shadow configuration and state, advanced once per accepted
   // request transaction. Expected register writes and finish words go to pending_rsp.
   // ---------------------------------------------------------------------------------------
   logic [23:0] cfg_present_tmo = 24'd10000000;
   logic [23:0] cfg_busy_tmo    = 24'd100000;
   logic [7:0]  cfg_retries     = 8'd200;
   logic [15:0] cfg_setup_dly   = 16'd10000;
   logic [15:0] cfg_cmd8_dly    = 16'd50000;
   logic [15:0] cfg_err_dly     = 16'd10000;
   logic [15:0] cfg_busy_dly    = 16'd5000;
   logic [31:0] cfg_phy         = 32'h0900_00FC;

   logic [3:0]  seq_phase    = PhIdle;
   count_type   countdown    = '0;
   logic [7:0]  retries_left = '0;

   rsp_type     pending_rsp[$];
   int unsigned results_this_item;

   // Mirror a configuration write; each register keeps only its own width.
   function automatic void apply_csr(input logic [2:0] index, input logic [31:0] value);
      case (index)
         CsrPresentTimeout: cfg_present_tmo = value[23:0];
         CsrBusyTimeout:    cfg_busy_tmo    = value[23:0];
         CsrInitRetries:    cfg_retries     = value[7:0];
         CsrSetupDelay:     cfg_setup_dly   = value[15:0];
         CsrCmd8Delay:      cfg_cmd8_dly    = value[15:0];
         CsrErrRetryDelay:  cfg_err_dly     = value[15:0];
         CsrBusyRetryDelay: cfg_busy_dly    = value[15:0];
         CsrPhyWord:        cfg_phy         = value;
         default: ;
      endcase
   endfunction

   // Append one result; only the newest result of a transaction carries last.
   function automatic void add_result(input rsp_type r);
      rsp_type prior;
      if (results_this_item != 0) begin
         prior = pending_rsp.pop_back();
         prior.last = 1'b0;
         pending_rsp.push_back(prior);
      end
      r.last = 1'b1;
      pending_rsp.push_back(r);
      results_this_item++;
   endfunction

   function automatic void queue_write(input logic [2:0] index, input logic [31:0] value);
      rsp_type r;
      r = '0;
      r.kind      = KindWrite;
      r.reg_index = index;
      r.reg_value = value;
      add_result(r);
   endfunction

   // Argument first, then the command word that fires it.
   function automatic void issue_command(input logic [31:0] arg, input logic [31:0] cmd);
      queue_write(RegData, arg);
      queue_write(RegCmd, cmd);
   endfunction

   function automatic void finish_sequence(input logic [2:0] st, input logic [31:0] ocr);
      rsp_type r;
      r = '0;
      r.kind          = KindFinish;
      r.status        = st;
      r.ocr           = ocr;
      r.high_capacity = ocr[30];
      add_result(r);
      seq_phase = PhIdle;
      countdown = '0;
   endfunction

   function automatic void start_loop_delay(input logic [15:0] ticks);
      countdown = count_type'(ticks);
      seq_phase = PhDlyLoop;
   endfunction

   function automatic void predict_sequencer(input req_type item);
      logic [31:0] cs;
      logic [31:0] dw;
      cs = item.cmd_status;
      dw = item.data_word;
      results_this_item = 0;
      case (item.opcode)
         OpStart: begin
            // Restart from the presence wait, whatever the phase.
            seq_phase    = PhPresent;
            countdown    = count_type'(cfg_present_tmo);
            retries_left = '0;
         end
         OpTick: begin
            if (seq_phase == PhDlySetup || seq_phase == PhDlyLoop) begin
               // A zero countdown is not decremented, so a zero delay still takes one tick.
               if (countdown != 0) countdown = countdown - 1'b1;
               if (countdown == 0) begin
                  if (seq_phase == PhDlySetup) begin
                     issue_command(32'd0, CmdWord0);
                     seq_phase = PhCmd0;
                     countdown = count_type'(cfg_busy_tmo);
                  end else if (retries_left == 0) begin
                     finish_sequence(StNotReady, '0);
                  end else begin
                     issue_command(32'd0, CmdWord55);
                     seq_phase = PhCmd55;
                  end
               end
            end
         end
         OpPoll: begin
            case (seq_phase)
               PhPresent: begin
                  // Pre-decrement: the poll that hits zero is not looked at.
                  countdown = countdown - 1'b1;
                  if (countdown == 0) begin
                     finish_sequence(StNoCard, '0);
                  end else if ((cs & BitPresentN) == 0) begin
                     queue_write(RegCmd, ClearWord);
                     queue_write(RegPhy, cfg_phy);
                     seq_phase = PhDlySetup;
                     countdown = count_type'(cfg_setup_dly);
                  end
               end
               PhCmd0: begin
                  countdown = countdown - 1'b1;
                  if (countdown == 0) begin
                     finish_sequence(StCmd0Tmo, '0);
                  end else if ((cs & MaskBusy) == 0) begin
                     issue_command(ArgCmd8, CmdWord8);
                     seq_phase = PhCmd8;
                     countdown = count_type'(cfg_busy_tmo);
                  end
               end
               PhCmd8: begin
                  countdown = countdown - 1'b1;
                  if (countdown == 0) begin
                     finish_sequence(StCmd8Tmo, '0);
                  end else if ((cs & MaskBusy) == 0) begin
                     if ((cs & BitErr) != 0) begin
                        finish_sequence(StCmd8Err, '0);
                     end else if (dw[7:0] != EchoPattern) begin
                        finish_sequence(StMismatch, '0);
                     end else begin
                        retries_left = cfg_retries;
                        start_loop_delay(cfg_cmd8_dly);
                     end
                  end
               end
               PhCmd55: begin
                  if ((cs & MaskBusy) == 0) begin
                     if ((cs & BitErr) != 0) begin
                        if (retries_left != 0) retries_left = retries_left - 1'b1;
                        start_loop_delay(cfg_err_dly);
                     end else begin
                        issue_command(ArgAcmd41, CmdWord41);
                        seq_phase = PhAcmd41;
                     end
                  end
               end
               PhAcmd41: begin
                  if ((cs & MaskBusy) == 0) begin
                     // OCR bit 31: card has left its busy state.
                     if (dw[31]) begin
                        finish_sequence(StOk, dw);
                     end else begin
                        if (retries_left != 0) retries_left = retries_left - 1'b1;
                        start_loop_delay(cfg_busy_dly);
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side: random gaps, mostly short, sometimes long, with calm stretches.
   // ---------------------------------------------------------------------------------------
   bit          hurry;
   int unsigned calm_left;

   function automatic int unsigned pick_req_gap();
      int unsigned roll;
      if (hurry) return 0;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request transaction. Call at a rising edge; valid is left high after the
   // handshake so that a back-to-back transaction never lowers and raises it in one step.
   task automatic send_req(input req_type item);
      int unsigned gap;
      gap = pick_req_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_sequencer(item);
   endtask

   task automatic send_fields(input logic [1:0] op, input logic [31:0] cs,
                              input logic [31:0] dw);
      req_type item;
      item.opcode     = op;
      item.cmd_status = cs;
      item.data_word  = dw;
      send_req(item);
   endtask

   // Hold requests until every expected result is out, then let the pipe settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Configuration writes; only issued after drain_results.
   // ---------------------------------------------------------------------------------------
   logic [31:0] setting_word [8];

   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(index, value);
   endtask

   task automatic program_settings();
      for (int i = 0; i < 8; i++) write_csr(3'(i), setting_word[i]);
      csr_valid <= 1'b0;
   endtask

   // Fill the bits above a register's width with noise half the time; they must be dropped.
   function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
      logic [31:0] junk;
      junk = $urandom();
      if ($urandom_range(0, 1) == 0) return value;
      return value | ((junk >> width) << width);
   endfunction

   function automatic void set_all(input logic [31:0] present, input logic [31:0] busy,
                                   input logic [31:0] retries, input logic [31:0] setup,
                                   input logic [31:0] cmd8, input logic [31:0] err_dly,
                                   input logic [31:0] busy_dly, input logic [31:0] phy);
      setting_word[CsrPresentTimeout] = with_junk(present, 24);
      setting_word[CsrBusyTimeout]    = with_junk(busy, 24);
      setting_word[CsrInitRetries]    = with_junk(retries, 8);
      setting_word[CsrSetupDelay]     = with_junk(setup, 16);
      setting_word[CsrCmd8Delay]      = with_junk(cmd8, 16);
      setting_word[CsrErrRetryDelay]  = with_junk(err_dly, 16);
      setting_word[CsrBusyRetryDelay] = with_junk(busy_dly, 16);
      setting_word[CsrPhyWord]        = phy;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Response side: ready stalls of random length plus stretches with no stall at all.
   // ---------------------------------------------------------------------------------------
   int unsigned stall_left;
   int unsigned free_left;
   int unsigned ready_roll;

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (free_left != 0) begin
            free_left--;
         end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 10) free_left = $urandom_range(50, 300);
            else if (ready_roll < 40) stall_left = $urandom_range(1, 3);
            else if (ready_roll < 43) stall_left = $urandom_range(10, 40);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result scoreboard: each accepted result against the oldest expectation.
   // ---------------------------------------------------------------------------------------
   int unsigned mismatches;
   rsp_type     oldest_rsp;

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $error("result with nothing expected: kind %0d reg_index %0d value 0x%0h",
                   rsp_data.kind, rsp_data.reg_index, rsp_data.reg_value);
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            compare_field("kind", 32'(oldest_rsp.kind), 32'(rsp_data.kind));
            compare_field("reg_index", 32'(oldest_rsp.reg_index), 32'(rsp_data.reg_index));
            compare_field("reg_value", oldest_rsp.reg_value, rsp_data.reg_value);
            compare_field("status", 32'(oldest_rsp.status), 32'(rsp_data.status));
            compare_field("ocr", oldest_rsp.ocr, rsp_data.ocr);
            compare_field("high_capacity", 32'(oldest_rsp.high_capacity),
                          32'(rsp_data.high_capacity));
            compare_field("last", 32'(oldest_rsp.last), 32'(rsp_data.last));
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends here.
   int unsigned cycle_count;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset values: the default presence budget must not fire early and the PHY write must
   // carry the default word; a start inside the setup delay restarts cleanly.
   task automatic test_reset_values();
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, BitPresentN, '0);
      send_fields(OpPoll, '0, '0);
      repeat (3) send_fields(OpTick, $urandom(), $urandom());
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, '0, '0);
   endtask

   // One short pass over each outcome that needs a fixed input pattern.
   task automatic test_directed_cases();
      drain_results();
      set_all(2, 3, 1, 0, 0, 0, 1, 32'hFFFF_FFFF);
      program_settings();
      // Stray items inside the setup delay: none emits a result.
      send_fields(OpTick, '0, '0);
      send_fields(OpPoll, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // No card: budget runs out on the second poll.
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, BitPresentN, '0);
      send_fields(OpPoll, BitPresentN, '0);
      // Zero setup delay still takes one tick; CMD0 ignores the error bit; CMD8 error.
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpTick, '0, '0);
      send_fields(OpPoll, MaskBusy, '0);
      send_fields(OpPoll, ~MaskBusy, '0);
      send_fields(OpPoll, ~MaskBusy, {24'd0, EchoPattern});
      // Echo pattern mismatch.
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpTick, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, 32'hFFFF_FF55);
      // Full bring-up of a high capacity card with an all-ones OCR.
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpTick, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, {24'd0, EchoPattern});
      send_fields(OpTick, '0, '0);
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, 32'hFFFF_FFFF);
   endtask

   task automatic tick_through_delay();
      while (seq_phase == PhDlySetup || seq_phase == PhDlyLoop)
         send_fields(OpTick, $urandom(), $urandom());
   endtask

   // Largest budgets and retry count with longer delays: walk every delay to its end once.
   task automatic test_longest_delays();
      drain_results();
      set_all(24'hFF_FFFF, 24'hFF_FFFF, 255, 16'd40, 16'd30, 16'd20, 16'd20,
              $urandom());
      program_settings();
      hurry = 1'b1;
      send_fields(OpStart, '0, '0);
      send_fields(OpPoll, '0, '0);
      tick_through_delay();
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, {24'd0, EchoPattern});
      tick_through_delay();
      // CMD55 error, then ACMD41 busy, then a ready standard capacity card.
      send_fields(OpPoll, BitErr, '0);
      tick_through_delay();
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, '0);
      tick_through_delay();
      send_fields(OpPoll, '0, '0);
      send_fields(OpPoll, '0, 32'h8000_0000);
      hurry = 1'b0;
   endtask

   // Build the next request from the predicted phase: mostly what a real card would answer
   // there, with random content, plus restarts, stray items and the unused opcode.
   function automatic req_type next_card_item();
      req_type     item;
      int unsigned roll;
      item.opcode     = OpPoll;
      item.cmd_status = $urandom();
      item.data_word  = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         item.opcode = OpStart;
      end else if (roll < 4) begin
         item.opcode = OpUnused;
      end else if (roll < 7) begin
         item.opcode = (seq_phase == PhDlySetup || seq_phase == PhDlyLoop) ? OpPoll : OpTick;
      end else begin
         case (seq_phase)
            PhIdle: item.opcode = OpStart;
            PhPresent: begin
               if ($urandom_range(0, 2) == 0) item.cmd_status |= BitPresentN;
               else item.cmd_status &= ~BitPresentN;
            end
            PhDlySetup, PhDlyLoop: item.opcode = OpTick;
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  if ((item.cmd_status & MaskBusy) == 0) item.cmd_status |= MaskBusy;
               end else begin
                  item.cmd_status &= ~MaskBusy;
               end
               if ($urandom_range(0, 5) == 0) item.cmd_status |= BitErr;
               else item.cmd_status &= ~BitErr;
               if ($urandom_range(0, 5) != 0) item.data_word[7:0] = EchoPattern;
               item.data_word[31] = ($urandom_range(0, 2) == 0);
            end
         endcase
      end
      return item;
   endfunction

   // Random traffic over several settings: minimums, zero retries, maximums, zero budgets
   // that wrap, and small random values.
   task automatic test_random_traffic();
      for (int round = 0; round < 8; round++) begin
         drain_results();
         set_all($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 4),
                 $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(0, 3), $urandom());
         case (round)
            0: set_all(1, 1, 1, 0, 0, 0, 0, 32'd0);
            1: setting_word[CsrInitRetries] = with_junk(0, 8);
            2: begin
               setting_word[CsrPresentTimeout] = with_junk(24'hFF_FFFF, 24);
               setting_word[CsrBusyTimeout]    = with_junk(24'hFF_FFFF, 24);
               setting_word[CsrInitRetries]    = with_junk(255, 8);
               setting_word[CsrPhyWord]        = 32'hFFFF_FFFF;
            end
            3: begin
               setting_word[CsrPresentTimeout] = with_junk(0, 24);
               setting_word[CsrBusyTimeout]    = with_junk(0, 24);
            end
            default: ;
         endcase
         program_settings();
         for (int i = 0; i < 112; i++) begin
            // Hold the sender until the result queue is empty now and then.
            if (i == 40 || $urandom_range(0, 59) == 0) drain_results();
            send_req(next_card_item());
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_cases();
      test_longest_delays();
      test_random_traffic();
      drain_results();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
